// ===== design/psfp_pkg.sv =====
// Shared types and constants for the particle sensor frame parser.
// No dependencies; imported by every module of the block except psfp_in_reg.
package psfp_pkg;

  // Frame header and length
  localparam logic [7:0] HDR_FIRST  = 8'h42;
  localparam logic [7:0] HDR_SECOND = 8'h4d;
  localparam int unsigned BODY_BYTES = 30;

  // Body positions (bytes counted after the header)
  localparam logic [4:0] POS_PM25_HI = 5'd4;
  localparam logic [4:0] POS_PM25_LO = 5'd5;
  localparam logic [4:0] POS_PM10_HI = 5'd6;
  localparam logic [4:0] POS_PM10_LO = 5'd7;
  localparam logic [4:0] POS_SUM_HI  = 5'd28;
  localparam logic [4:0] POS_LAST    = 5'(BODY_BYTES - 1);

  // Header bytes seed the running sum
  localparam logic [15:0] HDR_SUM = {8'h00, HDR_FIRST} + {8'h00, HDR_SECOND};

  // Status codes
  localparam logic STATUS_GOOD = 1'b0;
  localparam logic STATUS_BAD  = 1'b1;

  // Hunt state, one-hot
  typedef enum logic [2:0] {
    PH_HUNT   = 3'b001,
    PH_SECOND = 3'b010,
    PH_BODY   = 3'b100
  } phase_t;

  // Result handed from the parser to the output register
  typedef struct packed {
    logic        valid;
    logic        status;
    logic [15:0] pm25;
    logic [15:0] pm10;
  } result_t;

endpackage

// ===== design/particle_sensor_frame_parser.sv =====
// Particle sensor frame parser, top level.
// Two register stages: psfp_in_reg holds the byte, psfp_out_reg then raises result_valid.
// Throughput: one byte per cycle; input stalls only while a result waits under result_stall.
// Reset (rst, synchronous): hunt restarts, parser sums and readings clear to zero.
// Depends on psfp_pkg, psfp_in_reg, psfp_parser, psfp_out_reg.
module particle_sensor_frame_parser (
  input  logic        clk,
  input  logic        rst,
  input  logic        rx_valid,
  output logic        rx_stall,
  input  logic [7:0]  rx_byte,
  output logic        result_valid,
  input  logic        result_stall,
  output logic        status,
  output logic [15:0] pm25_reading,
  output logic [15:0] pm10_reading
);
  import psfp_pkg::*;

  logic       advance;
  logic       byte_valid;
  logic [7:0] byte_data;
  result_t    res;

  // Input byte register
  psfp_in_reg u_in_reg (
    .clk        (clk),
    .rst        (rst),
    .rx_valid   (rx_valid),
    .rx_stall   (rx_stall),
    .rx_byte    (rx_byte),
    .advance    (advance),
    .byte_valid (byte_valid),
    .byte_data  (byte_data)
  );

  // Frame parsing
  psfp_parser u_parser (
    .clk       (clk),
    .rst       (rst),
    .step      (byte_valid && advance),
    .byte_data (byte_data),
    .res       (res)
  );

  // Result register
  psfp_out_reg u_out_reg (
    .clk          (clk),
    .rst          (rst),
    .res          (res),
    .advance      (advance),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .status       (status),
    .pm25_reading (pm25_reading),
    .pm10_reading (pm10_reading)
  );

endmodule

// ===== design/psfp_in_reg.sv =====
// Input register of the frame parser: holds one received byte.
// No package dependencies; the parser consumes what it holds.
module psfp_in_reg (
  input  logic       clk,
  input  logic       rst,
  input  logic       rx_valid,
  output logic       rx_stall,
  input  logic [7:0] rx_byte,
  input  logic       advance,
  output logic       byte_valid,
  output logic [7:0] byte_data
);

  logic accept;

  // Take a new request whenever the held byte moves on or none is held
  assign rx_stall = byte_valid && !advance;
  assign accept   = rx_valid && !rx_stall;

  // Hold the valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_valid <= 1'b0;
    end else if (accept) begin
      byte_valid <= 1'b1;
    end else if (advance) begin
      byte_valid <= 1'b0;
    end
  end

  // Capture the byte
  always_ff @(posedge clk) begin
    if (accept) begin
      byte_data <= rx_byte;
    end
  end

endmodule

// ===== design/psfp_parser.sv =====
// Header hunt, checksum accumulation and reading capture, one byte a step.
// Depends on psfp_pkg for the header constants, phase_t and result_t.
module psfp_parser (
  input  logic                clk,
  input  logic                rst,
  input  logic                step,
  input  logic [7:0]          byte_data,
  output psfp_pkg::result_t   res
);
  import psfp_pkg::*;

  phase_t      phase, phase_next;
  logic [4:0]  byte_position, byte_position_next;
  logic [15:0] running_sum, running_sum_next;
  logic [7:0]  sent_sum_high, sent_sum_high_next;
  logic [15:0] frame_pm25, frame_pm25_next;
  logic [15:0] frame_pm10, frame_pm10_next;
  logic [15:0] good_pm25, good_pm25_next;
  logic [15:0] good_pm10, good_pm10_next;
  logic        bad;

  assign bad = ({sent_sum_high, byte_data} != running_sum);

  // Next state for one byte
  always_comb begin
    phase_next         = phase;
    byte_position_next = byte_position;
    running_sum_next   = running_sum;
    sent_sum_high_next = sent_sum_high;
    frame_pm25_next    = frame_pm25;
    frame_pm10_next    = frame_pm10;
    good_pm25_next     = good_pm25;
    good_pm10_next     = good_pm10;
    res.valid          = 1'b0;
    res.status         = STATUS_GOOD;
    res.pm25           = good_pm25;
    res.pm10           = good_pm10;
    unique case (phase)
      PH_SECOND: begin
        if (byte_data == HDR_SECOND) begin
          phase_next         = PH_BODY;
          byte_position_next = '0;
          running_sum_next   = HDR_SUM;
          sent_sum_high_next = '0;
          frame_pm25_next    = '0;
          frame_pm10_next    = '0;
        end else begin
          // broken header: drop this byte, hunt again from the next
          phase_next = PH_HUNT;
        end
      end
      PH_BODY: begin
        // sum covers frame bytes up to 29, i.e. body positions below 28
        if (byte_position < POS_SUM_HI) begin
          running_sum_next = running_sum + {8'h00, byte_data};
        end
        if (byte_position == POS_PM25_HI || byte_position == POS_PM25_LO) begin
          frame_pm25_next = {frame_pm25[7:0], byte_data};
        end
        if (byte_position == POS_PM10_HI || byte_position == POS_PM10_LO) begin
          frame_pm10_next = {frame_pm10[7:0], byte_data};
        end
        if (byte_position == POS_SUM_HI) begin
          sent_sum_high_next = byte_data;
        end
        if (byte_position == POS_LAST) begin
          // check and report, then forget the frame
          if (!bad) begin
            good_pm25_next = frame_pm25;
            good_pm10_next = frame_pm10;
          end
          res.valid          = step;
          res.status         = bad ? STATUS_BAD : STATUS_GOOD;
          res.pm25           = bad ? good_pm25 : frame_pm25;
          res.pm10           = bad ? good_pm10 : frame_pm10;
          phase_next         = PH_HUNT;
          byte_position_next = '0;
          running_sum_next   = '0;
          sent_sum_high_next = '0;
          frame_pm25_next    = '0;
          frame_pm10_next    = '0;
        end else begin
          byte_position_next = byte_position + 5'd1;
        end
      end
      default: begin
        phase_next = (byte_data == HDR_FIRST) ? PH_SECOND : PH_HUNT;
      end
    endcase
  end

  // Advance state on each byte
  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_HUNT;
      byte_position <= '0;
      running_sum   <= '0;
      sent_sum_high <= '0;
      frame_pm25    <= '0;
      frame_pm10    <= '0;
      good_pm25     <= '0;
      good_pm10     <= '0;
    end else if (step) begin
      phase         <= phase_next;
      byte_position <= byte_position_next;
      running_sum   <= running_sum_next;
      sent_sum_high <= sent_sum_high_next;
      frame_pm25    <= frame_pm25_next;
      frame_pm10    <= frame_pm10_next;
      good_pm25     <= good_pm25_next;
      good_pm10     <= good_pm10_next;
    end
  end

endmodule

// ===== design/psfp_out_reg.sv =====
// Result register of the frame parser, driving the result channel.
// Depends on psfp_pkg for result_t.
module psfp_out_reg (
  input  logic              clk,
  input  logic              rst,
  input  psfp_pkg::result_t res,
  output logic              advance,
  output logic              result_valid,
  input  logic              result_stall,
  output logic              status,
  output logic [15:0]       pm25_reading,
  output logic [15:0]       pm10_reading
);
  import psfp_pkg::*;

  // Upstream may move whenever this register is empty or draining
  assign advance = !result_valid || !result_stall;

  // Hold the valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (res.valid) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  // Load the payload
  always_ff @(posedge clk) begin
    if (res.valid) begin
      status       <= res.status;
      pm25_reading <= res.pm25;
      pm10_reading <= res.pm10;
    end
  end

endmodule

// ===== design/psfp_checker.sv =====
// Port-level checks for the particle sensor frame parser, bound to the top.
// Depends on psfp_pkg for the status codes.
module psfp_checker (
  input logic        clk,
  input logic        rst,
  input logic        rx_valid,
  input logic        rx_stall,
  input logic        result_valid,
  input logic        result_stall,
  input logic        status,
  input logic [15:0] pm25_reading,
  input logic [15:0] pm10_reading
);
  import psfp_pkg::*;

  logic [15:0] last_pm25;
  logic [15:0] last_pm10;
  logic        res_accept;

  assign res_accept = result_valid && !result_stall;

  // Track readings of the last delivered result
  always_ff @(posedge clk) begin
    if (rst) begin
      last_pm25 <= '0;
      last_pm10 <= '0;
    end else if (res_accept) begin
      last_pm25 <= pm25_reading;
      last_pm10 <= pm10_reading;
    end
  end

  // A stalled result stays valid
  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid)
    else $error("result dropped while stalled");

  // A stalled result keeps its payload
  a_hold_data: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=>
      $stable(status) && $stable(pm25_reading) && $stable(pm10_reading))
    else $error("result payload changed while stalled");

  // A new result rises only after a byte was accepted at the input and passed through the input and result registers
  a_rise_cause: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> $past(rx_valid && !rx_stall, 2))
    else $error("result appeared without a recent byte");

  // A bad frame repeats the readings of the last result
  a_bad_keeps: assert property (@(posedge clk) disable iff (rst)
    result_valid && status == STATUS_BAD |->
      pm25_reading == last_pm25 && pm10_reading == last_pm10)
    else $error("bad frame changed the readings");

endmodule

bind particle_sensor_frame_parser psfp_checker u_psfp_checker (
  .clk          (clk),
  .rst          (rst),
  .rx_valid     (rx_valid),
  .rx_stall     (rx_stall),
  .result_valid (result_valid),
  .result_stall (result_stall),
  .status       (status),
  .pm25_reading (pm25_reading),
  .pm10_reading (pm10_reading)
);
